// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the codec RTL.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define BSFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BSFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/bsfc_pkg.sv =====
// Package for the byte stuffing frame codec: codes, result plan type, helpers.
// No dependencies.
`timescale 1ns / 1ps

package bsfc_pkg;

  localparam logic [7:0] ESC_BYTE   = 8'd255;
  localparam logic [7:0] START_CODE = 8'd0;
  localparam logic [7:0] END_CODE   = 8'd1;

  localparam logic [15:0] RX_LIMIT_RESET = 16'd4096;
  localparam logic [15:0] TX_LIMIT_RESET = 16'd2048;

  localparam int unsigned BSFC_QUEUE_DEPTH = 4;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic REG_RX_LIMIT = 1'b0;
  localparam logic REG_TX_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    KIND_LINE  = 3'd0,
    KIND_DATA  = 3'd1,
    KIND_START = 3'd2,
    KIND_END   = 3'd3,
    KIND_ERROR = 3'd4
  } kind_e;

  // Result slots, emitted lowest first.
  localparam int unsigned NUM_SLOTS     = 6;
  localparam int unsigned SLOT_HEAD_ESC = 0;
  localparam int unsigned SLOT_HEAD_SOF = 1;
  localparam int unsigned SLOT_MAIN     = 2;
  localparam int unsigned SLOT_EXTRA    = 3;
  localparam int unsigned SLOT_TAIL_ESC = 4;
  localparam int unsigned SLOT_TAIL_EOF = 5;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    logic [7:0]           main_byte;
    kind_e                main_kind;
    logic [15:0]          main_len;
    logic                 extra_err;
  } plan_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

// ===== hw/rtl/bsfc_front.sv =====
// Front end: accepts input transactions, updates codec state, builds result plans.
// Depends on bsfc_pkg.
`timescale 1ns / 1ps

module bsfc_front import bsfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  input  logic [15:0] rx_limit_i,
  input  logic [15:0] tx_limit_i,
  input  logic        queue_full_i,
  output logic        push_o,
  output plan_t       plan_o
);

  logic        esc_q, esc_d;
  logic [15:0] rx_count_q, rx_count_d;
  logic [15:0] tx_count_q, tx_count_d;
  logic        accept;

  logic [15:0] tx_inc;
  logic [15:0] rx_inc;
  logic        tx_err;
  logic        counted;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    esc_d      = esc_q;
    rx_count_d = rx_count_q;
    tx_count_d = tx_count_q;
    plan_o     = '0;
    plan_o.main_kind = KIND_LINE;
    counted    = 1'b0;
    tx_inc     = sat_inc(first_byte_i ? 16'd0 : tx_count_q);
    tx_err     = tx_inc > tx_limit_i;
    rx_inc     = sat_inc(rx_count_q);

    if (mode_i == MODE_ENCODE) begin
      plan_o.mask[SLOT_HEAD_ESC] = first_byte_i;
      plan_o.mask[SLOT_HEAD_SOF] = first_byte_i;
      plan_o.mask[SLOT_MAIN]     = 1'b1;
      plan_o.mask[SLOT_EXTRA]    = !tx_err && (data_byte_i == ESC_BYTE);
      plan_o.mask[SLOT_TAIL_ESC] = last_byte_i;
      plan_o.mask[SLOT_TAIL_EOF] = last_byte_i;
      plan_o.main_byte = tx_err ? 8'd0 : data_byte_i;
      plan_o.main_kind = tx_err ? KIND_ERROR : KIND_LINE;
      tx_count_d = last_byte_i ? 16'd0 : tx_inc;
    end else begin
      if (esc_q) begin
        esc_d = 1'b0;
        if (data_byte_i == START_CODE) begin
          rx_count_d = '0;
          plan_o.mask[SLOT_MAIN] = 1'b1;
          plan_o.main_kind = KIND_START;
        end else if (data_byte_i == END_CODE) begin
          plan_o.mask[SLOT_MAIN] = 1'b1;
          plan_o.main_kind = KIND_END;
          plan_o.main_len  = rx_count_q;
        end else begin
          counted = 1'b1;
        end
      end else if (data_byte_i == ESC_BYTE) begin
        esc_d = 1'b1;
      end else begin
        counted = 1'b1;
      end
      if (counted) begin
        plan_o.mask[SLOT_MAIN] = 1'b1;
        plan_o.main_kind = KIND_DATA;
        plan_o.main_byte = data_byte_i;
        if (rx_inc == rx_limit_i) begin
          plan_o.mask[SLOT_EXTRA] = 1'b1;
          plan_o.extra_err = 1'b1;
          rx_count_d = '0;
        end else begin
          rx_count_d = rx_inc;
        end
      end
    end
  end

  assign push_o = accept && (plan_o.mask != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q      <= 1'b0;
      rx_count_q <= '0;
      tx_count_q <= '0;
    end else if (accept) begin
      esc_q      <= esc_d;
      rx_count_q <= rx_count_d;
      tx_count_q <= tx_count_d;
    end
  end

endmodule

// ===== hw/rtl/bsfc_queue.sv =====
// Plan queue between front and back end: small register FIFO.
// Depends on bsfc_pkg.
`timescale 1ns / 1ps

module bsfc_queue import bsfc_pkg::*; #(
  parameter int unsigned Depth = BSFC_QUEUE_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  plan_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output plan_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  plan_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/bsfc_back.sv =====
// Back end: walks each plan slot by slot and drives the output register.
// Depends on bsfc_pkg.
`timescale 1ns / 1ps

module bsfc_back import bsfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        queue_empty_i,
  input  plan_t       queue_data_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic [2:0]  kind_o,
  output logic [15:0] frame_length_o,
  output logic        final_result_o
);

  plan_t                cur_q;
  logic [NUM_SLOTS-1:0] mask_q, mask_d;
  logic [NUM_SLOTS-1:0] lowest, rest;
  logic                 emit;

  logic                 out_valid_q;
  logic [7:0]           out_byte_q, slot_byte;
  kind_e                kind_q, slot_kind;
  logic [15:0]          len_q, slot_len;
  logic                 final_q;

  assign lowest = mask_q & (~mask_q + 1'b1);
  assign rest   = mask_q & ~lowest;
  assign emit   = (mask_q != '0) && (!out_valid_q || out_ready_i);
  assign pop_o  = !queue_empty_i && ((mask_q == '0) || (emit && rest == '0));

  always_comb begin
    slot_byte = ESC_BYTE;
    slot_kind = KIND_LINE;
    slot_len  = '0;
    if (lowest[SLOT_HEAD_SOF]) begin
      slot_byte = START_CODE;
    end else if (lowest[SLOT_MAIN]) begin
      slot_byte = cur_q.main_byte;
      slot_kind = cur_q.main_kind;
      slot_len  = cur_q.main_len;
    end else if (lowest[SLOT_EXTRA] && cur_q.extra_err) begin
      slot_byte = 8'd0;
      slot_kind = KIND_ERROR;
    end else if (lowest[SLOT_TAIL_EOF]) begin
      slot_byte = END_CODE;
    end
  end

  always_comb begin
    mask_d = mask_q;
    if (pop_o) begin
      mask_d = queue_data_i.mask;
    end else if (emit) begin
      mask_d = rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= queue_data_i;
    end
    if (emit) begin
      out_byte_q <= slot_byte;
      kind_q     <= slot_kind;
      len_q      <= slot_len;
      final_q    <= (rest == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign kind_o         = kind_q;
  assign frame_length_o = len_q;
  assign final_result_o = final_q;

endmodule

// ===== hw/rtl/byte_stuffing_frame_codec.sv =====
// Byte stuffing frame codec. An input transaction is taken in any cycle the
// plan queue (QueueDepth entries) has room, so items can arrive back to back.
// Each item yields 0 to 6 result transactions (1 to 6, 0 for a decoded escape
// byte); the output register sends one result per cycle while out_ready_i does
// not hold it back. The output register and its one-result-per-cycle walk set
// the sustained rate.
// Depends on bsfc_pkg, bsfc_front, bsfc_queue, bsfc_back, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module byte_stuffing_frame_codec import bsfc_pkg::*; #(
  parameter int unsigned QueueDepth = BSFC_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic [2:0]  kind_o,
  output logic [15:0] frame_length_o,
  output logic        final_result_o
);

  logic [15:0] rx_limit_q, tx_limit_q;
  logic        reg_sel;
  logic        push, pop, full, empty;
  plan_t       push_plan, pop_plan;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign prdata  = {16'd0, (reg_sel == REG_TX_LIMIT) ? tx_limit_q : rx_limit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_limit_q <= RX_LIMIT_RESET;
      tx_limit_q <= TX_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (reg_sel == REG_RX_LIMIT) begin
        rx_limit_q <= pwdata[15:0];
      end else begin
        tx_limit_q <= pwdata[15:0];
      end
    end
  end

  bsfc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .data_byte_i  (data_byte_i),
    .first_byte_i (first_byte_i),
    .last_byte_i  (last_byte_i),
    .rx_limit_i   (rx_limit_q),
    .tx_limit_i   (tx_limit_q),
    .queue_full_i (full),
    .push_o       (push),
    .plan_o       (push_plan)
  );

  bsfc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_plan),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_plan)
  );

  bsfc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .queue_empty_i  (empty),
    .queue_data_i   (pop_plan),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .kind_o         (kind_o),
    .frame_length_o (frame_length_o),
    .final_result_o (final_result_o)
  );

  `BSFC_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !out_valid_o, "output valid in reset")
  `BSFC_ASSERT(a_end_is_final, out_valid_o && kind_o == KIND_END |-> final_result_o, "frame end not final")
  `BSFC_ASSERT(a_len_only_end, out_valid_o && kind_o != KIND_END |-> frame_length_o == 16'd0, "stray frame length")
  `BSFC_ASSERT(a_no_push_full, push |-> !full, "queue overrun")

endmodule
